// ===== rtl/gtbp_pkg.sv =====
// gtbp_pkg: types, codes and counter helper for the branch predictor unit.
// No dependencies; imported by gshare_tournament_branch_predictor_unit.
`default_nettype none

package gtbp_pkg;

  // predictor_mode register codes
  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_GSHARE = 2'd1,
    MODE_TOURN  = 2'd2,
    MODE_CUSTOM = 2'd3
  } mode_t;

  // configuration register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_GLEN = 2'd1,
    REG_LLEN = 2'd2,
    REG_PLEN = 2'd3
  } reg_idx_t;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_WEAK_NT  = 2'd1;  // counter reset: weakly not taken
  localparam ctr_t CTR_PREFER_G = 2'd2;  // choice reset: weakly prefer global
  localparam ctr_t CTR_MAX      = 2'd3;
  localparam ctr_t CTR_MIN      = 2'd0;

  localparam logic [3:0] GLEN_RST = 4'd13;
  localparam logic [3:0] LLEN_RST = 4'd11;
  localparam logic [3:0] PLEN_RST = 4'd11;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int IN_DW  = 40;   // branch_address + taken_outcome, byte padded
  localparam int OUT_DW = 8;    // predict_taken, byte padded

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // saturating step of a 2-bit counter
  function automatic ctr_t ctr_bump(ctr_t c, logic up);
    if (up) begin
      return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end
    return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gtbp_ram.sv =====
// gtbp_ram: generic simple dual-port RAM, one write and one registered read.
// Write-first on an address collision. No package dependency.
`default_nettype none

module gtbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/gshare_tournament_branch_predictor_unit.sv =====
// Top level of the conditional branch predictor (static, gshare, tournament,
// gshare-indexed tournament). Uses gtbp_pkg and four gtbp_ram instances.
`default_nettype none

// Channel   Dir  Handshake            Payload
// --------  ---  -------------------  -----------------------------------------
// in_       in   in_tvalid/in_tready  tdata: branch_address, taken_outcome
//                                     tuser: opcode (0 predict, 1 train)
// out_      out  out_tvalid/out_tready tdata: predict_taken
// cfg_      in   APB psel/penable     mode, ghist len, lhist len, pc index len
//
// Flow: one request per clock while in_tready is high; a result goes through
// stages 1 and 2 (two RAM reads, the local counter read depends on the local
// history read) and the result queue. Dependent requests are handled by forwarding.
// Reset: a clearing pass steps a max(MAX_GLOBAL_BITS, MAX_LOCAL_BITS, MAX_PC_BITS)
// bit counter (13 at the defaults) over every address and loads the tables; in_tready stays low meanwhile.
// Stalls: the pipeline never stops; a 4-entry result queue absorbs out_tready
// low, and in_tready drops while the queue plus in-flight requests are full.

module gshare_tournament_branch_predictor_unit #(
  parameter int MAX_GLOBAL_BITS = 13,
  parameter int MAX_LOCAL_BITS  = 11,
  parameter int MAX_PC_BITS     = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [gtbp_pkg::IN_DW-1:0]     in_tdata,   // [31:0] branch_address,
                                                          // [32] taken_outcome
  input  wire logic                           in_tuser,   // [0] opcode
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [gtbp_pkg::OUT_DW-1:0]    out_tdata,  // [0] predict_taken
  // configuration port
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [gtbp_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [gtbp_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [gtbp_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  import gtbp_pkg::*;

  localparam int G = MAX_GLOBAL_BITS;
  localparam int L = MAX_LOCAL_BITS;
  localparam int P = MAX_PC_BITS;
  localparam int GDEPTH = 1 << G;
  localparam int LDEPTH = 1 << L;
  localparam int PDEPTH = 1 << P;
  localparam int CLR_W  = (G > L) ? ((G > P) ? G : P) : ((L > P) ? L : P);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mode_t      mode_r;
  logic [3:0] glen_r, llen_r, plen_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GSHARE;
      glen_r <= GLEN_RST;
      llen_r <= LLEN_RST;
      plen_r <= PLEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE: mode_r <= mode_t'(cfg_pwdata[1:0]);
        REG_GLEN: glen_r <= cfg_pwdata[3:0];
        REG_LLEN: llen_r <= cfg_pwdata[3:0];
        REG_PLEN: plen_r <= cfg_pwdata[3:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE: cfg_prdata = {{(CFG_DW-2){1'b0}}, mode_r};
      REG_GLEN: cfg_prdata = {{(CFG_DW-4){1'b0}}, glen_r};
      REG_LLEN: cfg_prdata = {{(CFG_DW-4){1'b0}}, llen_r};
      REG_PLEN: cfg_prdata = {{(CFG_DW-4){1'b0}}, plen_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // Index masks: a length above the maximum saturates; custom mode uses all.
  logic [G-1:0] gmask;
  logic [L-1:0] lmask;
  logic [P-1:0] pmask;

  always_comb begin
    for (int i = 0; i < G; i++) begin
      gmask[i] = (mode_r == MODE_CUSTOM) || (32'(glen_r) > 32'(i));
    end
    for (int i = 0; i < L; i++) begin
      lmask[i] = (mode_r == MODE_CUSTOM) || (32'(llen_r) > 32'(i));
    end
    for (int i = 0; i < P; i++) begin
      pmask[i] = (mode_r == MODE_CUSTOM) || (32'(plen_r) > 32'(i));
    end
  end

  // ---------------------------------------------------------------------------
  // Table clearing pass after reset
  // ---------------------------------------------------------------------------
  logic             clr_busy_r;
  logic [CLR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: index from the global history, issue first RAM reads
  // ---------------------------------------------------------------------------
  logic         in_acc;
  logic [31:0]  pc0;
  logic         outc0;
  logic         op0;
  logic [G-1:0] gh_r;
  logic [G:0]   gh_shift;
  logic [G-1:0] gidx0;
  logic [P-1:0] pidx0;

  assign in_acc = in_tvalid & in_tready;
  assign pc0    = in_tdata[31:0];
  assign outc0  = in_tdata[32];
  assign op0    = in_tuser;

  assign gidx0    = ((mode_r == MODE_TOURN) ? gh_r : (gh_r ^ pc0[G-1:0])) & gmask;
  assign pidx0    = pc0[P-1:0] & pmask;
  assign gh_shift = {gh_r, outc0};

  // The global history only needs the outcome, so shift it in at accept time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gh_r <= '0;
    end else if (in_acc && op0 && (mode_r != MODE_STATIC)) begin
      gh_r <= gh_shift[G-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: global/choice counters and local history arrive
  // ---------------------------------------------------------------------------
  logic         v1_r;
  logic         op1_r, outc1_r;
  mode_t        mode1_r;
  logic [G-1:0] gidx1_r;
  logic [P-1:0] pidx1_r;
  logic [L-1:0] lmask1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    op1_r    <= op0;
    outc1_r  <= outc0;
    mode1_r  <= mode_r;
    gidx1_r  <= gidx0;
    pidx1_r  <= pidx0;
    lmask1_r <= lmask;
  end

  ctr_t         gc_rdata, cc_rdata, lc_rdata;
  logic [L-1:0] lh_rdata;
  ctr_t         gctr1, cctr1;
  logic [L-1:0] lhist1;
  logic [L-1:0] lidx1;

  // stage-2 training writes (declared here for forwarding)
  logic         trn2, loc2;
  logic [G-1:0] gidx2_r;
  logic [P-1:0] pidx2_r;
  logic [L-1:0] lidx2_r;
  ctr_t         gnew2, cnew2, lnew2;
  logic [L-1:0] lhnew2;

  // The request one ahead writes this cycle; take its data on a match.
  assign gctr1  = (trn2 && (gidx2_r == gidx1_r)) ? gnew2  : gc_rdata;
  assign cctr1  = (loc2 && (gidx2_r == gidx1_r)) ? cnew2  : cc_rdata;
  assign lhist1 = (loc2 && (pidx2_r == pidx1_r)) ? lhnew2 : lh_rdata;
  assign lidx1  = lhist1 & lmask1_r;

  // ---------------------------------------------------------------------------
  // Stage 2: local counter arrives; predict and train
  // ---------------------------------------------------------------------------
  logic         v2_r;
  logic         op2_r, outc2_r;
  mode_t        mode2_r;
  ctr_t         gctr2_r, cctr2_r;
  logic [L-1:0] lhist2_r;
  logic [L:0]   lh_shift;
  logic         gpred2, lpred2, pred2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op2_r    <= op1_r;
    outc2_r  <= outc1_r;
    mode2_r  <= mode1_r;
    gidx2_r  <= gidx1_r;
    pidx2_r  <= pidx1_r;
    lidx2_r  <= lidx1;
    gctr2_r  <= gctr1;
    cctr2_r  <= cctr1;
    lhist2_r <= lhist1;
  end

  assign gpred2 = gctr2_r[1];
  assign lpred2 = lc_rdata[1];

  always_comb begin
    case (mode2_r)
      MODE_STATIC: pred2 = 1'b1;
      MODE_GSHARE: pred2 = gpred2;
      default:     pred2 = cctr2_r[1] ? gpred2 : lpred2;
    endcase
  end

  assign trn2 = v2_r & op2_r & (mode2_r != MODE_STATIC);
  assign loc2 = trn2 & (mode2_r != MODE_GSHARE);

  // Choice moves only when exactly one side was right.
  always_comb begin
    if ((gpred2 == outc2_r) && (lpred2 != outc2_r)) begin
      cnew2 = ctr_bump(cctr2_r, 1'b1);
    end else if ((gpred2 != outc2_r) && (lpred2 == outc2_r)) begin
      cnew2 = ctr_bump(cctr2_r, 1'b0);
    end else begin
      cnew2 = cctr2_r;
    end
  end

  assign gnew2    = ctr_bump(gctr2_r, outc2_r);
  assign lnew2    = ctr_bump(lc_rdata, outc2_r);
  assign lh_shift = {lhist2_r, outc2_r};
  assign lhnew2   = lh_shift[L-1:0];

  // ---------------------------------------------------------------------------
  // Tables: the clearing pass owns the write ports until it ends
  // ---------------------------------------------------------------------------
  logic         gc_we, cc_we, lh_we, lc_we;
  logic [G-1:0] gc_waddr, cc_waddr;
  logic [P-1:0] lh_waddr;
  logic [L-1:0] lc_waddr;
  ctr_t         gc_wdata, cc_wdata, lc_wdata;
  logic [L-1:0] lh_wdata;

  assign gc_we    = clr_busy_r | trn2;
  assign gc_waddr = clr_busy_r ? clr_cnt_r[G-1:0] : gidx2_r;
  assign gc_wdata = clr_busy_r ? CTR_WEAK_NT : gnew2;

  assign cc_we    = clr_busy_r | loc2;
  assign cc_waddr = clr_busy_r ? clr_cnt_r[G-1:0] : gidx2_r;
  assign cc_wdata = clr_busy_r ? CTR_PREFER_G : cnew2;

  assign lh_we    = clr_busy_r | loc2;
  assign lh_waddr = clr_busy_r ? clr_cnt_r[P-1:0] : pidx2_r;
  assign lh_wdata = clr_busy_r ? '0 : lhnew2;

  assign lc_we    = clr_busy_r | loc2;
  assign lc_waddr = clr_busy_r ? clr_cnt_r[L-1:0] : lidx2_r;
  assign lc_wdata = clr_busy_r ? CTR_WEAK_NT : lnew2;

  // global counters, shared by gshare and the global side of the tournament
  gtbp_ram #(.WIDTH(2), .DEPTH(GDEPTH)) u_gctr (
    .clk   (clk),
    .we    (gc_we),
    .waddr (gc_waddr),
    .wdata (gc_wdata),
    .raddr (gidx0),
    .rdata (gc_rdata)
  );

  gtbp_ram #(.WIDTH(2), .DEPTH(GDEPTH)) u_cctr (
    .clk   (clk),
    .we    (cc_we),
    .waddr (cc_waddr),
    .wdata (cc_wdata),
    .raddr (gidx0),
    .rdata (cc_rdata)
  );

  gtbp_ram #(.WIDTH(L), .DEPTH(PDEPTH)) u_lhist (
    .clk   (clk),
    .we    (lh_we),
    .waddr (lh_waddr),
    .wdata (lh_wdata),
    .raddr (pidx0),
    .rdata (lh_rdata)
  );

  gtbp_ram #(.WIDTH(2), .DEPTH(LDEPTH)) u_lctr (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .raddr (lidx1),
    .rdata (lc_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result queue and request credit
  // ---------------------------------------------------------------------------
  logic               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [FIFO_CW-1:0] credit;
  logic               push, pop;

  assign push = v2_r;
  assign pop  = out_tvalid & out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= pred2;
    end
  end

  // Requests in flight always have a queue slot waiting for them.
  assign credit    = cnt_r + FIFO_CW'(v1_r) + FIFO_CW'(v2_r);
  assign in_tready = !clr_busy_r && (credit < FIFO_CW'(FIFO_DEPTH));

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {{(OUT_DW-1){1'b0}}, fifo_r[rd_ptr_r]};

endmodule

`default_nettype wire

// ===== dv/tb_gshare_tournament_branch_predictor_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gshare_tournament_branch_predictor_unit: directed and
// random branch requests over all four modes, checked against an in-bench model.
// Depends on gtbp_pkg and the unit's RTL only.

module tb_gshare_tournament_branch_predictor_unit;
  import gtbp_pkg::*;

  localparam int GBITS          = 13;
  localparam int LBITS          = 11;
  localparam int PBITS          = 11;
  localparam int HOLD_CYCLES    = 64;    // long receiver hold-off in the pressure phase
  localparam int PHASES         = 12;
  localparam int REQS_PER_PHASE = 162;
  localparam int DRAIN_CYCLES   = 12;    // results pass stages 1, 2 and the result queue after accept

  localparam bit OP_PREDICT = 1'b0;
  localparam bit OP_TRAIN   = 1'b1;

  // Direction model: own copy of the registers and tables, a queue of guesses
  // in request order, and the mismatch count.
  class branch_direction_tracker;
    mode_t            mode;
    logic [3:0]       glen, llen, plen;
    logic [GBITS-1:0] ghist;
    ctr_t             gctr[1 << GBITS];
    ctr_t             choice[1 << GBITS];
    logic [LBITS-1:0] lhist[1 << PBITS];
    ctr_t             lctr[1 << LBITS];
    bit               pending_guesses[$];
    int               errors;
    int               checked;

    function new();
      mode  = MODE_GSHARE;
      glen  = GLEN_RST;
      llen  = LLEN_RST;
      plen  = PLEN_RST;
      ghist = '0;
      foreach (gctr[i]) gctr[i] = CTR_WEAK_NT;
      foreach (choice[i]) choice[i] = CTR_PREFER_G;
      foreach (lhist[i]) lhist[i] = '0;
      foreach (lctr[i]) lctr[i] = CTR_WEAK_NT;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_MODE: mode = mode_t'(value[1:0]);
        REG_GLEN: glen = value[3:0];
        REG_LLEN: llen = value[3:0];
        REG_PLEN: plen = value[3:0];
        default: ;
      endcase
    endfunction

    // a length above its maximum saturates; zero gives an empty mask
    function logic [31:0] len_mask(logic [3:0] len, int maxlen);
      int n;
      n = (int'(len) > maxlen) ? maxlen : int'(len);
      return (32'd1 << n) - 32'd1;
    endfunction

    function ctr_t sat_step(ctr_t c, bit up);
      if (up) return (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
      return (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
    endfunction

    // Guess for one accepted request, then train if it asks for it.
    function void note_request(bit op, logic [31:0] pc, bit taken);
      logic [31:0]      gm, lm, pm;
      logic [GBITS-1:0] gi;
      logic [PBITS-1:0] pi;
      logic [LBITS-1:0] li;
      bit               gp, lp, guess;
      if (mode == MODE_STATIC) begin
        pending_guesses.push_back(1'b1);
        return;
      end
      if (mode == MODE_CUSTOM) begin
        // custom mode always runs at full table sizes
        gm = len_mask(4'(GBITS), GBITS);
        lm = len_mask(4'(LBITS), LBITS);
        pm = len_mask(4'(PBITS), PBITS);
      end else begin
        gm = len_mask(glen, GBITS);
        lm = len_mask(llen, LBITS);
        pm = len_mask(plen, PBITS);
      end
      if (mode == MODE_TOURN) gi = ghist & gm[GBITS-1:0];
      else gi = (ghist ^ pc[GBITS-1:0]) & gm[GBITS-1:0];
      pi = pc[PBITS-1:0] & pm[PBITS-1:0];
      li = lhist[pi] & lm[LBITS-1:0];
      gp = gctr[gi] > 2'd1;
      lp = lctr[li] > 2'd1;
      if (mode == MODE_GSHARE) guess = gp;
      else guess = (choice[gi] < 2'd2) ? lp : gp;
      pending_guesses.push_back(guess);
      if (op != OP_TRAIN) return;
      if (mode != MODE_GSHARE) begin
        // choice moves only when exactly one side got it right
        if (gp == taken && lp != taken) choice[gi] = sat_step(choice[gi], 1'b1);
        else if (gp != taken && lp == taken) choice[gi] = sat_step(choice[gi], 1'b0);
        lctr[li] = sat_step(lctr[li], taken);
        lhist[pi] = {lhist[pi][LBITS-2:0], taken};
      end
      gctr[gi] = sat_step(gctr[gi], taken);
      ghist = {ghist[GBITS-2:0], taken};
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_guess(logic got);
      bit want;
      if (pending_guesses.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding", checked));
        checked++;
        return;
      end
      want = pending_guesses.pop_front();
      if (got !== want)
        report_mismatch($sformatf("result %0d: predict_taken %b, model gives %b",
                                  checked, got, want));
      checked++;
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Signals; every input of the unit starts at a known value
  // ---------------------------------------------------------------------------
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata    = '0;   // [31:0] branch_address, [32] taken_outcome
  logic                in_tuser    = 1'b0; // [0] opcode
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;          // [0] predict_taken
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Idling controls set by the main sequence and read by the sender and the receiver
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;
  bit long_hold     = 1'b0;

  int n_reqs     = 0;
  int n_train    = 0;
  int n_settings = 1;   // the reset setting counts as the first

  branch_direction_tracker tracker;

  gshare_tournament_branch_predictor_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap and hold it until accepted. Valid is
  // only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_branch(bit op, logic [31:0] pc, bit taken);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DW - 33){1'b0}}, taken, pc};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(op, pc, taken);
    n_reqs++;
    if (op == OP_TRAIN) n_train++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.pending_guesses.size() != 0) @(posedge clk);
  endtask

  // Write all four registers; setup then access, psel held across the writes.
  task automatic program_regs(mode_t m, logic [3:0] gl, logic [3:0] ll, logic [3:0] pl);
    reg_idx_t    order[4] = '{REG_MODE, REG_GLEN, REG_LLEN, REG_PLEN};
    logic [31:0] vals[4];
    vals = '{32'(m), 32'(gl), 32'(ll), 32'(pl)};
    for (int i = 0; i < 4; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {order[i], 2'b00};
      cfg_pwdata  <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      tracker.write_reg(order[i], vals[i]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    n_settings++;
  endtask

  // Random phase. Most requests come from a small pool of loop-like branches
  // (taken except once per trip) so counters saturate, histories fill and the
  // choice table moves; a few pool entries alias others in the low address
  // bits. The rest are fully random requests.
  task automatic run_phase(int count);
    logic [31:0] pool[8];
    int          period[8];
    int          trip[8];
    int          k;
    bit          op, taken;
    logic [31:0] pc;
    foreach (pool[i]) begin
      if (i >= 6) pool[i] = pool[i - 6] ^ (32'd1 << $urandom_range(PBITS, 31));
      else pool[i] = $urandom();
      period[i] = $urandom_range(1, 6);
      trip[i]   = 0;
    end
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) begin
        k     = $urandom_range(0, 7);
        pc    = pool[k];
        op    = ($urandom_range(0, 99) < 80) ? OP_TRAIN : OP_PREDICT;
        taken = (trip[k] != period[k] - 1);
        if ($urandom_range(0, 99) < 5) taken = !taken;
        if (op == OP_TRAIN) trip[k] = (trip[k] + 1) % period[k];
      end else begin
        pc    = $urandom();
        op    = $urandom_range(0, 1) ? OP_TRAIN : OP_PREDICT;
        taken = 1'($urandom_range(0, 1));
      end
      send_branch(op, pc, taken);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready gaps, plus one long hold-off counted here when the
  // main sequence asks for it; every accepted result goes to the checker.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        gap = receiver_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_guess(out_tdata[0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mode_t      phase_modes[4];
    logic [3:0] gl, ll, pl;
    phase_modes = '{MODE_GSHARE, MODE_TOURN, MODE_CUSTOM, MODE_STATIC};
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting (gshare, full lengths): address and outcome extremes.
    // Requests are offered during the clearing pass and held until taken.
    send_branch(OP_PREDICT, 32'h0000_0000, 1'b0);
    send_branch(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
    repeat (3) send_branch(OP_TRAIN, 32'h0000_0040, 1'b1);
    send_branch(OP_TRAIN, 32'hFFFF_FFFF, 1'b0);
    send_branch(OP_PREDICT, 32'h0000_0040, 1'b0);
    wait_drained();

    // Static mode: always taken, and training leaves the tables alone
    program_regs(MODE_STATIC, GLEN_RST, LLEN_RST, PLEN_RST);
    send_branch(OP_PREDICT, 32'h0000_1234, 1'b0);
    send_branch(OP_TRAIN, 32'h0000_1234, 1'b0);
    wait_drained();

    // Tournament with zero lengths: every index collapses onto entry zero
    program_regs(MODE_TOURN, 4'd0, 4'd0, 4'd0);
    repeat (3) send_branch(OP_TRAIN, 32'hABCD_0000, 1'b1);
    send_branch(OP_TRAIN, 32'h0000_0005, 1'b0);
    send_branch(OP_PREDICT, 32'h0000_0005, 1'b0);
    wait_drained();

    // Lengths above their maximum saturate
    program_regs(MODE_TOURN, 4'd15, 4'd15, 4'd15);
    send_branch(OP_TRAIN, 32'h8000_0001, 1'b1);
    send_branch(OP_TRAIN, 32'h8000_0001, 1'b0);
    send_branch(OP_PREDICT, 32'h8000_0001, 1'b1);
    wait_drained();

    // Custom mode ignores the length registers
    program_regs(MODE_CUSTOM, 4'd1, 4'd1, 4'd1);
    repeat (2) send_branch(OP_TRAIN, 32'h7FFF_FFFE, 1'b1);
    send_branch(OP_PREDICT, 32'h0000_FFFF, 1'b0);
    wait_drained();

    // Random phases; tables carry over from one setting to the next
    for (int p = 0; p < PHASES; p++) begin
      gl = 4'($urandom_range(0, 15));
      ll = 4'($urandom_range(0, 15));
      pl = 4'($urandom_range(0, 15));
      case (p)
        1: begin gl = 4'd1;  ll = 4'd1;  pl = 4'd1;  end
        4: begin gl = 4'd0;  ll = 4'd0;  pl = 4'd0;  end
        5: begin gl = 4'd13; ll = 4'd11; pl = 4'd11; end
        8: begin gl = 4'd15; ll = 4'd15; pl = 4'd15; end
        9: begin gl = 4'd0;  ll = 4'd15; pl = 4'd1;  end
        default: ;
      endcase
      // phase 5: sender runs flat out while the receiver holds off, so the
      // result queue fills and in_tready drops; phase 6: no idling anywhere
      sender_gaps   = (p != 5) && (p != 6);
      receiver_gaps = (p != 6);
      program_regs(phase_modes[p % 4], gl, ll, pl);
      if (p == 5) long_hold = 1'b1;
      run_phase(REQS_PER_PHASE);
    end

    // Let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d branch requests (%0d training) over %0d register settings, all modes.",
             n_reqs, n_train, n_settings);
    $display("Compared %0d predictions, %0d mismatches.", tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_gshare_tournament_branch_predictor_unit passed");
    end else begin
      $display("tb_gshare_tournament_branch_predictor_unit failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing pass included
  initial begin
    #3_200_000;
    $display("Timeout with %0d results still outstanding.", tracker.pending_guesses.size());
    $display("tb_gshare_tournament_branch_predictor_unit failed");
    $finish;
  end

endmodule
